// ----- sv/seg_isect_pkg.sv -----
// shared constants, request types and helpers for the segment intersection pipeline
package seg_isect_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 48;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int DEN_W      = CROSS_W - 1;
    localparam int NUMER_W    = DEN_W + DIFF_W;
    localparam int QUO_W      = NUMER_W + FRAC_BITS;
    localparam int SUM_W      = 64;
    localparam int CAP_LOG    = 62;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] p_ax;
        logic signed [COORD_BITS-1:0] p_ay;
        logic signed [COORD_BITS-1:0] p_bx;
        logic signed [COORD_BITS-1:0] p_by;
        logic                         p_infinite;
        logic signed [COORD_BITS-1:0] q_ax;
        logic signed [COORD_BITS-1:0] q_ay;
        logic signed [COORD_BITS-1:0] q_bx;
        logic signed [COORD_BITS-1:0] q_by;
        logic                         q_infinite;
    } pair_req_t;

    typedef struct packed {
        logic                       hit;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } point_req_t;

    function automatic logic lex_less(
        input logic signed [COORD_BITS-1:0] ax,
        input logic signed [COORD_BITS-1:0] ay,
        input logic signed [COORD_BITS-1:0] bx,
        input logic signed [COORD_BITS-1:0] by
    );
        return (ax < bx) || ((ax == bx) && (ay < by));
    endfunction

endpackage

// ----- sv/segment_intersection_top.sv -----
// segment intersection pipeline: cross products, pipelined restoring divider, saturation
// from request accepted to point shown: 5 front stages, 67 divider stages, 2 tail stages;
// one request accepted every cycle while the point side is not stalled
// a stall on the point side freezes the whole pipeline and is returned as pair_stall
// reset clears the valid bits only, data registers are not reset
module segment_intersection_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pair_valid,
    output logic                      pair_stall,
    input  seg_isect_pkg::pair_req_t  pair,
    output logic                      point_valid,
    input  logic                      point_stall,
    output seg_isect_pkg::point_req_t point
);

    localparam int CB = seg_isect_pkg::COORD_BITS;
    localparam int DW = seg_isect_pkg::DIFF_W;
    localparam int PW = seg_isect_pkg::PROD_W;
    localparam int XW = seg_isect_pkg::CROSS_W;
    localparam int NW = seg_isect_pkg::DEN_W;
    localparam int MW = seg_isect_pkg::NUMER_W;
    localparam int QW = seg_isect_pkg::QUO_W;
    localparam int SW = seg_isect_pkg::SUM_W;
    localparam int OW = seg_isect_pkg::OUT_BITS;
    localparam int FB = seg_isect_pkg::FRAC_BITS;
    localparam int CL = seg_isect_pkg::CAP_LOG;

    typedef struct packed {
        logic                 hit;
        logic                 general;
        logic                 neg_x;
        logic                 neg_y;
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
    } side_t;

    logic adv;
    assign adv        = !point_valid || !point_stall;
    assign pair_stall = !adv;

    // stage 1: differences and lexicographic overlap
    logic                 v1_reg;
    logic signed [DW-1:0] pdx_reg, pdy_reg, qdx_reg, qdy_reg, wx_reg, wy_reg;
    logic signed [CB-1:0] pax1_reg, pay1_reg, ox1_reg, oy1_reg;
    logic                 pinf1_reg, qinf1_reg, ovl1_reg;

    logic signed [CB-1:0] lpx, lpy, hpx, hpy, lqx, lqy, hqx, hqy;
    logic signed [CB-1:0] xax, xay, xbx, xby;
    logic                 ovl_next;

    always_comb
    begin
        if (seg_isect_pkg::lex_less(pair.p_bx, pair.p_by, pair.p_ax, pair.p_ay))
        begin
            lpx = pair.p_bx; lpy = pair.p_by; hpx = pair.p_ax; hpy = pair.p_ay;
        end
        else
        begin
            lpx = pair.p_ax; lpy = pair.p_ay; hpx = pair.p_bx; hpy = pair.p_by;
        end
        if (seg_isect_pkg::lex_less(pair.q_bx, pair.q_by, pair.q_ax, pair.q_ay))
        begin
            lqx = pair.q_bx; lqy = pair.q_by; hqx = pair.q_ax; hqy = pair.q_ay;
        end
        else
        begin
            lqx = pair.q_ax; lqy = pair.q_ay; hqx = pair.q_bx; hqy = pair.q_by;
        end
        if (seg_isect_pkg::lex_less(lpx, lpy, lqx, lqy))
        begin
            xax = lqx; xay = lqy;
        end
        else
        begin
            xax = lpx; xay = lpy;
        end
        if (seg_isect_pkg::lex_less(hqx, hqy, hpx, hpy))
        begin
            xbx = hqx; xby = hqy;
        end
        else
        begin
            xbx = hpx; xby = hpy;
        end
        ovl_next = !seg_isect_pkg::lex_less(xbx, xby, xax, xay);
    end

    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] m_pq_reg, m_qp_reg, m_qw1_reg, m_qw2_reg, m_pw1_reg, m_pw2_reg;
    logic signed [DW-1:0] pdx2_reg, pdy2_reg;
    logic signed [CB-1:0] pax2_reg, pay2_reg, ox2_reg, oy2_reg;
    logic                 pinf2_reg, qinf2_reg, ovl2_reg;

    // stage 3: cross values
    logic                 v3_reg;
    logic signed [XW-1:0] s_reg, t1_reg, t2_reg;
    logic signed [DW-1:0] pdx3_reg, pdy3_reg;
    logic signed [CB-1:0] pax3_reg, pay3_reg, ox3_reg, oy3_reg;
    logic                 pinf3_reg, qinf3_reg, ovl3_reg;

    // stage 4: sign fold, hit decision, magnitudes
    logic                 v4_reg;
    logic [NW-1:0]        den4_reg, t1m4_reg;
    logic [DW-1:0]        pxm4_reg, pym4_reg;
    side_t                side4_reg;

    logic signed [XW-1:0] s_abs, t1n, t2n;
    logic                 r1, r2;
    side_t                side4_next;

    always_comb
    begin
        s_abs = s_reg[XW-1] ? -s_reg : s_reg;
        t1n   = s_reg[XW-1] ? -t1_reg : t1_reg;
        t2n   = s_reg[XW-1] ? -t2_reg : t2_reg;
        r1    = (!t1n[XW-1] && (t1n <= s_abs)) || pinf3_reg;
        r2    = (!t2n[XW-1] && (t2n <= s_abs)) || qinf3_reg;
        side4_next.general = (s_reg != '0);
        side4_next.neg_x   = t1n[XW-1] ^ pdx3_reg[DW-1];
        side4_next.neg_y   = t1n[XW-1] ^ pdy3_reg[DW-1];
        if (s_reg != '0)
        begin
            side4_next.hit = r1 && r2;
            side4_next.px  = pax3_reg;
            side4_next.py  = pay3_reg;
        end
        else if (t2_reg != '0)
        begin
            side4_next.hit = 1'b0;
            side4_next.px  = '0;
            side4_next.py  = '0;
        end
        else if (pinf3_reg || qinf3_reg)
        begin
            side4_next.hit = 1'b1;
            side4_next.px  = pax3_reg;
            side4_next.py  = pay3_reg;
        end
        else
        begin
            side4_next.hit = ovl3_reg;
            side4_next.px  = ovl3_reg ? ox3_reg : '0;
            side4_next.py  = ovl3_reg ? oy3_reg : '0;
        end
    end

    // divider stage 0 is the dividend stage
    logic          dv_reg   [0:QW];
    logic [NW-1:0] den_reg  [0:QW];
    logic [NW-1:0] remx_reg [0:QW];
    logic [NW-1:0] remy_reg [0:QW];
    logic [QW-1:0] qx_reg   [0:QW];
    logic [QW-1:0] qy_reg   [0:QW];
    side_t         side_reg [0:QW];

    logic [MW-1:0] numx, numy;
    assign numx = MW'(t1m4_reg) * MW'(pxm4_reg);
    assign numy = MW'(t1m4_reg) * MW'(pym4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            dv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg   <= pair_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            dv_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pdx_reg   <= DW'(pair.p_bx) - DW'(pair.p_ax);
            pdy_reg   <= DW'(pair.p_by) - DW'(pair.p_ay);
            qdx_reg   <= DW'(pair.q_bx) - DW'(pair.q_ax);
            qdy_reg   <= DW'(pair.q_by) - DW'(pair.q_ay);
            wx_reg    <= DW'(pair.p_ax) - DW'(pair.q_ax);
            wy_reg    <= DW'(pair.p_ay) - DW'(pair.q_ay);
            pax1_reg  <= pair.p_ax;
            pay1_reg  <= pair.p_ay;
            ox1_reg   <= xax;
            oy1_reg   <= xay;
            pinf1_reg <= pair.p_infinite;
            qinf1_reg <= pair.q_infinite;
            ovl1_reg  <= ovl_next;

            m_pq_reg  <= PW'(pdx_reg) * PW'(qdy_reg);
            m_qp_reg  <= PW'(pdy_reg) * PW'(qdx_reg);
            m_qw1_reg <= PW'(qdx_reg) * PW'(wy_reg);
            m_qw2_reg <= PW'(qdy_reg) * PW'(wx_reg);
            m_pw1_reg <= PW'(pdx_reg) * PW'(wy_reg);
            m_pw2_reg <= PW'(pdy_reg) * PW'(wx_reg);
            pdx2_reg  <= pdx_reg;
            pdy2_reg  <= pdy_reg;
            pax2_reg  <= pax1_reg;
            pay2_reg  <= pay1_reg;
            ox2_reg   <= ox1_reg;
            oy2_reg   <= oy1_reg;
            pinf2_reg <= pinf1_reg;
            qinf2_reg <= qinf1_reg;
            ovl2_reg  <= ovl1_reg;

            s_reg     <= XW'(m_pq_reg) - XW'(m_qp_reg);
            t1_reg    <= XW'(m_qw1_reg) - XW'(m_qw2_reg);
            t2_reg    <= XW'(m_pw1_reg) - XW'(m_pw2_reg);
            pdx3_reg  <= pdx2_reg;
            pdy3_reg  <= pdy2_reg;
            pax3_reg  <= pax2_reg;
            pay3_reg  <= pay2_reg;
            ox3_reg   <= ox2_reg;
            oy3_reg   <= oy2_reg;
            pinf3_reg <= pinf2_reg;
            qinf3_reg <= qinf2_reg;
            ovl3_reg  <= ovl2_reg;

            den4_reg  <= s_abs[NW-1:0];
            t1m4_reg  <= t1n[XW-1] ? NW'(-t1n) : NW'(t1n);
            pxm4_reg  <= pdx3_reg[DW-1] ? DW'(-pdx3_reg) : DW'(pdx3_reg);
            pym4_reg  <= pdy3_reg[DW-1] ? DW'(-pdy3_reg) : DW'(pdy3_reg);
            side4_reg <= side4_next;

            den_reg[0]  <= den4_reg;
            remx_reg[0] <= '0;
            remy_reg[0] <= '0;
            qx_reg[0]   <= QW'(numx) << FB;
            qy_reg[0]   <= QW'(numy) << FB;
            side_reg[0] <= side4_reg;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [NW:0]   shx, shy, dfx, dfy;
        logic          gex, gey;

        always_comb
        begin
            shx = {remx_reg[k], qx_reg[k][QW-1]};
            shy = {remy_reg[k], qy_reg[k][QW-1]};
            dfx = shx - {1'b0, den_reg[k]};
            dfy = shy - {1'b0, den_reg[k]};
            gex = !dfx[NW];
            gey = !dfy[NW];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
                remx_reg[k+1] <= gex ? dfx[NW-1:0] : shx[NW-1:0];
                remy_reg[k+1] <= gey ? dfy[NW-1:0] : shy[NW-1:0];
                qx_reg[k+1]   <= {qx_reg[k][QW-2:0], gex};
                qy_reg[k+1]   <= {qy_reg[k][QW-2:0], gey};
            end
        end
    end

    // tail 1: cap and sign
    localparam logic [QW-1:0] CAP = QW'(1) << CL;

    logic                 vt_reg;
    logic signed [SW-1:0] offx_reg, offy_reg;
    side_t                sidet_reg;
    logic [QW-1:0]        capx, capy;
    logic [SW-1:0]        magx, magy;

    always_comb
    begin
        capx = (qx_reg[QW] > CAP) ? CAP : qx_reg[QW];
        capy = (qy_reg[QW] > CAP) ? CAP : qy_reg[QW];
        magx = SW'(capx[CL:0]);
        magy = SW'(capy[CL:0]);
    end

    // tail 2: add base point and saturate
    localparam logic signed [SW-1:0] TOP = (SW'(1) << (OW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] BOT = -TOP - SW'(1);

    logic signed [SW-1:0]      sumx, sumy;
    seg_isect_pkg::point_req_t point_next;

    always_comb
    begin
        sumx = SW'(sidet_reg.px) <<< FB;
        sumy = SW'(sidet_reg.py) <<< FB;
        if (sidet_reg.general)
        begin
            sumx = sumx + offx_reg;
            sumy = sumy + offy_reg;
        end
        point_next.hit = sidet_reg.hit;
        if (sumx > TOP)
            point_next.cross_x = TOP[OW-1:0];
        else if (sumx < BOT)
            point_next.cross_x = BOT[OW-1:0];
        else
            point_next.cross_x = sumx[OW-1:0];
        if (sumy > TOP)
            point_next.cross_y = TOP[OW-1:0];
        else if (sumy < BOT)
            point_next.cross_y = BOT[OW-1:0];
        else
            point_next.cross_y = sumy[OW-1:0];
    end

    logic                      point_valid_reg;
    seg_isect_pkg::point_req_t point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vt_reg          <= 1'b0;
            point_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vt_reg          <= dv_reg[QW];
            point_valid_reg <= vt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            offx_reg  <= side_reg[QW].neg_x ? -magx : magx;
            offy_reg  <= side_reg[QW].neg_y ? -magy : magy;
            sidet_reg <= side_reg[QW];
            point_reg <= point_next;
        end
    end

    assign point_valid = point_valid_reg;
    assign point       = point_reg;

endmodule

// ----- sv/seg_isect_checker.sv -----
// port checker for the segment intersection pipeline and its bind
module seg_isect_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      pair_valid,
    input logic                      pair_stall,
    input seg_isect_pkg::pair_req_t  pair,
    input logic                      point_valid,
    input logic                      point_stall,
    input seg_isect_pkg::point_req_t point
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !point_valid)
        else $error("point valid during reset");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point_stall) |-> pair_stall)
        else $error("request taken while output blocked");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> (point_valid && point_stall))
        else $error("request side stalled without output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point_stall) |=> (point_valid && $stable(point)))
        else $error("stalled point changed");

endmodule

bind segment_intersection_top seg_isect_checker u_seg_isect_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pair_valid  (pair_valid),
    .pair_stall  (pair_stall),
    .pair        (pair),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point)
);

// ----- bench/segment_intersection_checker.sv -----
// checker for the segment intersection block: predicts each point and compares it
module segment_intersection_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pair_valid,
    input  logic                      pair_stall,
    input  seg_isect_pkg::pair_req_t  pair,
    input  logic                      point_valid,
    input  logic                      point_stall,
    input  seg_isect_pkg::point_req_t point,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OB = seg_isect_pkg::OUT_BITS;
    localparam int FB = seg_isect_pkg::FRAC_BITS;

    seg_isect_pkg::point_req_t expected_points[$];

    function automatic longint scaled_quot(longint num, longint abv, longint den);
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] cap;
        bit neg;
        longint un;
        longint ua;
        neg = (num < 0) != (abv < 0);
        un = (num < 0) ? -num : num;
        ua = (abv < 0) ? -abv : abv;
        cap = 128'd1 << seg_isect_pkg::CAP_LOG;
        mag = 128'(un) * 128'(ua);
        mag = mag << FB;
        q = mag / 128'(den);
        if (q > cap)
            q = cap;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic [OB-1:0] clamp_out(longint v);
        longint top;
        longint bot;
        top = (longint'(1) <<< (OB - 1)) - 1;
        bot = -top - 1;
        if (v > top)
            v = top;
        if (v < bot)
            v = bot;
        return v[OB-1:0];
    endfunction

    function automatic bit lex_lt(longint ax, longint ay, longint bx, longint by);
        return (ax < bx) || ((ax == bx) && (ay < by));
    endfunction

    function automatic seg_isect_pkg::point_req_t predict_point(seg_isect_pkg::pair_req_t r);
        seg_isect_pkg::point_req_t res;
        longint pax, pay, pbx, pby, qax, qay, qbx, qby;
        longint pdx, pdy, qdx, qdy, wx, wy, s, t1, t2, ox, oy, t;
        longint lax, lay, lbx, lby, rax, ray, rbx, rby, xax, xay, xbx, xby;
        bit hit;
        pax = r.p_ax; pay = r.p_ay; pbx = r.p_bx; pby = r.p_by;
        qax = r.q_ax; qay = r.q_ay; qbx = r.q_bx; qby = r.q_by;
        pdx = pbx - pax; pdy = pby - pay;
        qdx = qbx - qax; qdy = qby - qay;
        wx = pax - qax; wy = pay - qay;
        s = pdx * qdy - pdy * qdx;
        hit = 0;
        ox = 0;
        oy = 0;
        if (s == 0) begin
            if ((-wx) * pdy - (-wy) * pdx == 0) begin
                if (r.p_infinite || r.q_infinite) begin
                    hit = 1;
                    ox = pax <<< FB;
                    oy = pay <<< FB;
                end
                else begin
                    lax = pax; lay = pay; lbx = pbx; lby = pby;
                    rax = qax; ray = qay; rbx = qbx; rby = qby;
                    if (lex_lt(lbx, lby, lax, lay)) begin
                        t = lax; lax = lbx; lbx = t;
                        t = lay; lay = lby; lby = t;
                    end
                    if (lex_lt(rbx, rby, rax, ray)) begin
                        t = rax; rax = rbx; rbx = t;
                        t = ray; ray = rby; rby = t;
                    end
                    if (lex_lt(lax, lay, rax, ray)) begin
                        xax = rax; xay = ray;
                    end
                    else begin
                        xax = lax; xay = lay;
                    end
                    if (lex_lt(rbx, rby, lbx, lby)) begin
                        xbx = rbx; xby = rby;
                    end
                    else begin
                        xbx = lbx; xby = lby;
                    end
                    if (!lex_lt(xbx, xby, xax, xay)) begin
                        hit = 1;
                        ox = xax <<< FB;
                        oy = xay <<< FB;
                    end
                end
            end
        end
        else begin
            t1 = qdx * wy - qdy * wx;
            t2 = pdx * wy - pdy * wx;
            if (s < 0) begin
                t1 = -t1;
                t2 = -t2;
                s = -s;
            end
            hit = ((t1 >= 0 && t1 <= s) || r.p_infinite)
                && ((t2 >= 0 && t2 <= s) || r.q_infinite);
            ox = (pax <<< FB) + scaled_quot(t1, pdx, s);
            oy = (pay <<< FB) + scaled_quot(t1, pdy, s);
        end
        res.hit = hit;
        res.cross_x = clamp_out(ox);
        res.cross_y = clamp_out(oy);
        return res;
    endfunction

    task automatic report(string what, logic [OB-1:0] got, logic [OB-1:0] want);
        $display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
    end

    assign pending = expected_points.size();

    always @(posedge clk) begin
        seg_isect_pkg::point_req_t want;
        if (rst_n) begin
            if (pair_valid && !pair_stall)
                expected_points.insert(expected_points.size(), predict_point(pair));
            if (point_valid && !point_stall) begin
                if (expected_points.size() == 0) begin
                    report("unexpected request", '0, '0);
                end
                else begin
                    want = expected_points.pop_front();
                    if (point.hit !== want.hit)
                        report("hit", OB'(point.hit), OB'(want.hit));
                    if (point.cross_x !== want.cross_x)
                        report("cross_x", point.cross_x, want.cross_x);
                    if (point.cross_y !== want.cross_y)
                        report("cross_y", point.cross_y, want.cross_y);
                end
            end
        end
    end

endmodule

// ----- bench/segment_intersection_top_tb.sv -----
// top of the segment intersection bench: clock, reset, stimulus and verdict
module segment_intersection_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PAIRS = 1600;
    localparam int DRAIN_CYCLES = 100;
    localparam int CB           = seg_isect_pkg::COORD_BITS;

    logic                      clk;
    logic                      rst_n;
    logic                      pair_valid;
    logic                      pair_stall;
    seg_isect_pkg::pair_req_t  pair;
    logic                      point_valid;
    logic                      point_stall;
    seg_isect_pkg::point_req_t point;
    int                        fail_count;
    int                        pending;

    segment_intersection_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pair_valid  (pair_valid),
        .pair_stall  (pair_stall),
        .pair        (pair),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

    segment_intersection_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pair_valid  (pair_valid),
        .pair_stall  (pair_stall),
        .pair        (pair),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic seg_isect_pkg::pair_req_t build_pair(
        int pax, int pay, int pbx, int pby, bit pinf,
        int qax, int qay, int qbx, int qby, bit qinf);
        seg_isect_pkg::pair_req_t r;
        r.p_ax = CB'(pax); r.p_ay = CB'(pay); r.p_bx = CB'(pbx); r.p_by = CB'(pby);
        r.p_infinite = pinf;
        r.q_ax = CB'(qax); r.q_ay = CB'(qay); r.q_bx = CB'(qbx); r.q_by = CB'(qby);
        r.q_infinite = qinf;
        return r;
    endfunction

    function automatic int small_coord();
        return int'($urandom_range(0, 64)) - 32;
    endfunction

    function automatic int full_coord();
        return int'($signed(16'($urandom)));
    endfunction

    // segments on one line or parallel to it, with random content
    function automatic seg_isect_pkg::pair_req_t shaped_pair(int kind);
        int ax, ay, dx, dy, k, m, off;
        seg_isect_pkg::pair_req_t r;
        ax = int'($urandom_range(0, 2000)) - 1000;
        ay = int'($urandom_range(0, 2000)) - 1000;
        dx = small_coord();
        dy = small_coord();
        k = int'($urandom_range(0, 20)) - 10;
        m = int'($urandom_range(0, 20)) - 10;
        off = ($urandom_range(0, 1) == 1) ? 1 : 0;
        r = build_pair(ax, ay, ax + dx * int'($urandom_range(1, 5)),
                       ay + dy * int'($urandom_range(1, 5)), $urandom_range(0, 7) == 0,
                       ax + dx * k + off * dy, ay + dy * k - off * dx,
                       ax + dx * m + off * dy, ay + dy * m - off * dx,
                       $urandom_range(0, 7) == 0);
        if (kind == 1)
        begin
            r.p_bx = CB'(ax + dx);
            r.p_by = CB'(ay + dy);
        end
        return r;
    endfunction

    function automatic seg_isect_pkg::pair_req_t random_pair();
        int sel;
        sel = int'($urandom_range(0, 9));
        if (sel < 3)
            return build_pair(full_coord(), full_coord(), full_coord(), full_coord(),
                              $urandom_range(0, 1) == 1, full_coord(), full_coord(),
                              full_coord(), full_coord(), $urandom_range(0, 1) == 1);
        if (sel < 6)
            return build_pair(small_coord(), small_coord(), small_coord(), small_coord(),
                              $urandom_range(0, 3) == 0, small_coord(), small_coord(),
                              small_coord(), small_coord(), $urandom_range(0, 3) == 0);
        return shaped_pair(sel & 1);
    endfunction

    task automatic send_pair(seg_isect_pkg::pair_req_t r);
        pair <= r;
        pair_valid <= 1'b1;
        do
            @(posedge clk);
        while (pair_stall);
    endtask

    task automatic idle_sender(int cycles);
        pair_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    seg_isect_pkg::pair_req_t directed[$];

    initial begin
        int burst;
        int sent;
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair = '0;
        directed = '{
            build_pair(0, 0, 10, 10, 0, 0, 10, 10, 0, 0),
            build_pair(0, 0, 10, 0, 0, 5, -5, 5, 5, 0),
            build_pair(0, 0, 10, 0, 0, 20, -5, 20, 5, 0),
            build_pair(0, 0, 10, 0, 1, 20, -5, 20, 5, 0),
            build_pair(0, 0, 10, 0, 0, 20, -5, 20, 5, 1),
            build_pair(0, 0, 10, 0, 0, 5, 0, 20, 0, 0),
            build_pair(10, 0, 0, 0, 0, 20, 0, 15, 0, 0),
            build_pair(0, 0, 10, 0, 0, 20, 0, 30, 0, 0),
            build_pair(0, 0, 10, 0, 1, 20, 0, 30, 0, 0),
            build_pair(0, 0, 10, 0, 0, 20, 0, 30, 0, 1),
            build_pair(0, 0, 10, 0, 0, 0, 1, 10, 1, 0),
            build_pair(3, 4, 3, 4, 0, 7, 8, 9, 1, 0),
            build_pair(3, 4, 3, 4, 0, 3, 4, 3, 4, 0),
            build_pair(0, 0, 0, 10, 0, 0, 5, 0, 7, 0),
            build_pair(0, 0, 3, 7, 0, 5, 0, 0, 4, 0),
            build_pair(-32768, -32768, 32767, 32767, 0, -32768, 32767, 32767, -32768, 0),
            build_pair(32767, 32767, -32768, -32768, 1, 32767, -32768, -32768, 32767, 1),
            build_pair(-32768, 0, -32767, 1, 1, 32767, 0, 32767, 1, 1),
            build_pair(0, 0, 1, 0, 1, 32767, -32768, -32768, 32767, 1),
            build_pair(-32768, -32768, -32768, -32768, 0, 32767, 32767, 32767, 32767, 0),
            build_pair(0, 0, 32767, 1, 1, 0, 0, 32767, 2, 1),
            build_pair(-1, -1, -1, -1, 1, -1, -1, -1, -1, 1)
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_pair(directed[i]);
        sent = 0;
        while (sent < RANDOM_PAIRS) begin
            burst = int'($urandom_range(1, 40));
            while (burst > 0 && sent < RANDOM_PAIRS) begin
                send_pair(random_pair());
                burst--;
                sent++;
            end
            if (sent >= 800 && sent < 840) begin
                // hold off until the pipeline has drained
                pair_valid <= 1'b0;
                while (pending != 0) @(posedge clk);
                sent = 840;
            end
            else if ($urandom_range(0, 2) != 0) begin
                idle_sender(int'($urandom_range(1, 8)));
            end
        end
        pair_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int cycle;
        int hold;
        point_stall = 1'b0;
        cycle = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            cycle++;
            if (cycle == 400) begin
                // long hold so the pipeline fills and backs up
                point_stall <= 1'b1;
                for (hold = 0; hold < 300; hold++)
                    @(posedge clk);
                cycle += 300;
            end
            if ((cycle / 150) % 3 == 0)
                point_stall <= 1'b0;
            else if ((cycle / 150) % 3 == 1)
                point_stall <= ($urandom_range(0, 3) == 0);
            else
                point_stall <= ((cycle % 7) < 3);
        end
    end

    initial begin
        #3ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
